>>> rtl/cpt_pkg.sv
// Shared widths and region codes for the closest-point-on-triangle pipeline.
`timescale 1ns / 1ps
`default_nettype none
package cpt_pkg;

  // Coordinate width, Q12.12 by default
  localparam int COORD_WIDTH = 24;
  localparam int CW    = COORD_WIDTH;
  // Vertex and point differences
  localparam int DFW   = CW + 1;
  // Dot products of differences, three terms summed
  localparam int DOTW  = 2 * DFW + 2;
  localparam int HALFW = DOTW / 2;
  // Partial product of split dot products
  localparam int PPDW  = 2 * HALFW + 2;
  // Products of dot products and the region terms va, vb, vc
  localparam int PRODW = 2 * DOTW;
  localparam int VAW   = PRODW + 1;
  localparam int DENW  = PRODW + 3;
  // Weight split into four chunks for the numerator multiply
  localparam int NCH   = 4;
  localparam int CHW   = (VAW + NCH - 1) / NCH;
  localparam int PPW   = CHW + 1 + DFW;
  localparam int TERMW = VAW + DFW;
  localparam int NUMW  = TERMW + 1;
  // Quotient bits kept; anything larger saturates the coordinate
  localparam int QB    = CW + 1;
  localparam int CMPW  = DENW + QB;

  // Stream word widths, padded to whole bytes
  localparam int IN_W  = ((12 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((3 * CW + 7) / 8) * 8;
  localparam int RGW   = 3;

  // Pipeline depth: front stages plus the divider
  localparam int FRONT = 11;
  localparam int DIVL  = QB + 2;
  localparam int TOTAL = FRONT + DIVL;

  typedef enum logic [RGW-1:0] {
    REG_A   = 3'd0,
    REG_B   = 3'd1,
    REG_C   = 3'd2,
    REG_AB  = 3'd3,
    REG_AC  = 3'd4,
    REG_BC  = 3'd5,
    REG_IN  = 3'd6,
    REG_DEG = 3'd7
  } region_t;

endpackage
`default_nettype wire

>>> rtl/cpt_div.sv
// Pipelined restoring divider per axis, one quotient bit per stage, with base add and clamp.
`timescale 1ns / 1ps
`default_nettype none
module cpt_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [cpt_pkg::NUMW-1:0]          un,
  input  logic [cpt_pkg::DENW-1:0]          ud,
  input  logic                              neg,
  input  logic signed [cpt_pkg::CW-1:0]     base,
  output logic signed [cpt_pkg::CW-1:0]     near
);
  import cpt_pkg::*;

  logic [DENW-1:0]         rr   [0:QB];
  logic [QB-1:0]           qq   [0:QB];
  logic [QB-1:0]           lo   [0:QB];
  logic [DENW-1:0]         dd   [0:QB];
  logic                    ng   [0:QB];
  logic                    ov   [0:QB];
  logic signed [CW-1:0]    bs   [0:QB];

  // Entry: detect quotient overflow, load the top of the numerator
  always_ff @(posedge clk) begin
    if (en) begin
      ov[0] <= CMPW'(un) >= {ud, {QB{1'b0}}};
      rr[0] <= DENW'(un >> QB);
      lo[0] <= un[QB-1:0];
      qq[0] <= '0;
      dd[0] <= ud;
      ng[0] <= neg;
      bs[0] <= base;
    end
  end

  // One quotient bit per stage
  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DENW:0] trial;
    logic          hit;
    always_comb begin
      trial = {rr[i-1], lo[i-1][QB-i]};
      hit   = trial >= {1'b0, dd[i-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rr[i] <= hit ? DENW'(trial - {1'b0, dd[i-1]}) : DENW'(trial);
        qq[i] <= {qq[i-1][QB-2:0], hit};
        lo[i] <= lo[i-1];
        dd[i] <= dd[i-1];
        ng[i] <= ng[i-1];
        ov[i] <= ov[i-1];
        bs[i] <= bs[i-1];
      end
    end
  end

  // Apply sign, add base, clamp to the coordinate range
  logic signed [QB:0]   qs;
  logic signed [QB+1:0] sm;
  logic signed [CW-1:0] near_next;
  always_comb begin
    qs = ng[QB] ? -$signed({1'b0, qq[QB]}) : $signed({1'b0, qq[QB]});
    sm = (QB+2)'(bs[QB]) + (QB+2)'(qs);
    if (ov[QB]) begin
      near_next = ng[QB] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else if (sm[QB+1:CW-1] != {(QB+3-CW){sm[QB+1]}}) begin
      near_next = sm[QB+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      near_next = sm[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near <= near_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/closest_point_on_triangle.sv
// Top level: closest point on a triangle by Voronoi region tests, fully pipelined.
// Depth: 11 front stages plus a 27-stage divider.
// Throughput: one word per cycle; the whole pipe advances when the output is free or taken.
// The divider retires one quotient bit per stage, which sets most of the depth.
// Reset (rst, synchronous, active high) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
module closest_point_on_triangle (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: query_x, query_y, query_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
  input  logic [cpt_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: near_x, near_y, near_z
  output logic [cpt_pkg::OUT_W-1:0]     m_tdata,
  // m_tuser: region
  output logic [cpt_pkg::RGW-1:0]       m_tuser
);
  import cpt_pkg::*;

  logic en;
  logic vld [1:TOTAL];

  assign en       = !vld[TOTAL] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOTAL];

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 1; i <= TOTAL; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[1] <= s_tvalid;
      for (int i = 2; i <= TOTAL; i++) vld[i] <= vld[i-1];
    end
  end

  // Unpack input word
  logic signed [CW-1:0] pin [3], ain [3], bin [3], cin [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pin[k] = s_tdata[k*CW +: CW];
      ain[k] = s_tdata[(3+k)*CW +: CW];
      bin[k] = s_tdata[(6+k)*CW +: CW];
      cin[k] = s_tdata[(9+k)*CW +: CW];
    end
  end

  // Geometry carried to the decision stage
  logic signed [DFW-1:0] gab [1:7][3], gac [1:7][3], gbc [1:7][3];
  logic signed [CW-1:0]  ga  [1:7][3], gb  [1:7][3], gc  [1:7][3];
  logic signed [DFW-1:0] ap1 [3], bp1 [3], cp1 [3];

  // Stage 1: differences
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        gab[1][k] <= DFW'(bin[k]) - DFW'(ain[k]);
        gac[1][k] <= DFW'(cin[k]) - DFW'(ain[k]);
        gbc[1][k] <= DFW'(cin[k]) - DFW'(bin[k]);
        ap1[k]    <= DFW'(pin[k]) - DFW'(ain[k]);
        bp1[k]    <= DFW'(pin[k]) - DFW'(bin[k]);
        cp1[k]    <= DFW'(pin[k]) - DFW'(cin[k]);
        ga[1][k]  <= ain[k];
        gb[1][k]  <= bin[k];
        gc[1][k]  <= cin[k];
      end
      for (int i = 2; i <= 7; i++) begin
        for (int k = 0; k < 3; k++) begin
          gab[i][k] <= gab[i-1][k];
          gac[i][k] <= gac[i-1][k];
          gbc[i][k] <= gbc[i-1][k];
          ga[i][k]  <= ga[i-1][k];
          gb[i][k]  <= gb[i-1][k];
          gc[i][k]  <= gc[i-1][k];
        end
      end
    end
  end

  // Stage 2: per-axis products for d1..d6
  logic signed [2*DFW-1:0] pr2 [6][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pr2[0][k] <= gab[1][k] * ap1[k];
        pr2[1][k] <= gac[1][k] * ap1[k];
        pr2[2][k] <= gab[1][k] * bp1[k];
        pr2[3][k] <= gac[1][k] * bp1[k];
        pr2[4][k] <= gab[1][k] * cp1[k];
        pr2[5][k] <= gac[1][k] * cp1[k];
      end
    end
  end

  // Stage 3: dot products d1..d6 (index 0..5); carried to stage 6
  logic signed [DOTW-1:0] d3s [6], d4s [6], d5s [6], d6s [6];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        d3s[j] <= DOTW'(pr2[j][0]) + DOTW'(pr2[j][1]) + DOTW'(pr2[j][2]);
        d4s[j] <= d3s[j];
        d5s[j] <= d4s[j];
        d6s[j] <= d5s[j];
      end
    end
  end

  // Stage 4: split products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
  localparam int PX [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PY [6] = '{3, 1, 1, 5, 5, 3};
  logic signed [PPDW-1:0] pp4 [6][4];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        pp4[j][0] <= $signed(d3s[PX[j]][DOTW-1:HALFW]) * $signed(d3s[PY[j]][DOTW-1:HALFW]);
        pp4[j][1] <= $signed(d3s[PX[j]][DOTW-1:HALFW])
                     * $signed({1'b0, d3s[PY[j]][HALFW-1:0]});
        pp4[j][2] <= $signed({1'b0, d3s[PX[j]][HALFW-1:0]})
                     * $signed(d3s[PY[j]][DOTW-1:HALFW]);
        pp4[j][3] <= $signed({1'b0, d3s[PX[j]][HALFW-1:0]})
                     * $signed({1'b0, d3s[PY[j]][HALFW-1:0]});
      end
    end
  end

  // Stage 5: recombine products
  logic signed [PRODW-1:0] prod5 [6];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        prod5[j] <= (PRODW'(pp4[j][0]) <<< (2*HALFW))
                  + ((PRODW'(pp4[j][1]) + PRODW'(pp4[j][2])) <<< HALFW)
                  + PRODW'(pp4[j][3]);
      end
    end
  end

  // Stage 6: region terms and edge differences
  logic signed [VAW-1:0]    va6, vb6, vc6;
  logic signed [DOTW:0]     e1_6, e2_6, eab6, eac6;
  always_ff @(posedge clk) begin
    if (en) begin
      vc6  <= VAW'(prod5[0]) - VAW'(prod5[1]);
      vb6  <= VAW'(prod5[2]) - VAW'(prod5[3]);
      va6  <= VAW'(prod5[4]) - VAW'(prod5[5]);
      e1_6 <= (DOTW+1)'(d5s[3]) - (DOTW+1)'(d5s[2]);
      e2_6 <= (DOTW+1)'(d5s[4]) - (DOTW+1)'(d5s[5]);
      eab6 <= (DOTW+1)'(d5s[0]) - (DOTW+1)'(d5s[2]);
      eac6 <= (DOTW+1)'(d5s[1]) - (DOTW+1)'(d5s[5]);
    end
  end

  // Stage 7: pick region, weights, edges and divisor
  logic signed [DENW-1:0] denom, den_n;
  logic signed [DOTW+1:0] ebc;
  logic signed [VAW-1:0]  m1_n, m2_n;
  logic signed [DFW-1:0]  e1x_n [3];
  logic signed [CW-1:0]   base_n [3];
  region_t                rg_n;
  logic signed [DOTW-1:0] d1, d2, d3, d4, d5, d6;

  always_comb begin
    d1 = d6s[0]; d2 = d6s[1]; d3 = d6s[2];
    d4 = d6s[3]; d5 = d6s[4]; d6 = d6s[5];
    denom = DENW'(va6) + DENW'(vb6) + DENW'(vc6);
    ebc   = (DOTW+2)'(e1_6) + (DOTW+2)'(e2_6);
    m1_n  = '0;
    m2_n  = '0;
    den_n = DENW'(1);
    rg_n  = REG_A;
    for (int k = 0; k < 3; k++) begin
      e1x_n[k]  = gab[6][k];
      base_n[k] = ga[6][k];
    end
    if (d1 <= 0 && d2 <= 0) begin
      rg_n = REG_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      rg_n = REG_B;
      for (int k = 0; k < 3; k++) base_n[k] = gb[6][k];
    end else if (d6 >= 0 && d5 <= d6) begin
      rg_n = REG_C;
      for (int k = 0; k < 3; k++) base_n[k] = gc[6][k];
    end else if (vc6 <= 0 && d1 >= 0 && d3 <= 0) begin
      if (eab6 == 0) begin
        rg_n = REG_DEG;
      end else begin
        rg_n  = REG_AB;
        m1_n  = VAW'(d1);
        den_n = DENW'(eab6);
      end
    end else if (vb6 <= 0 && d2 >= 0 && d6 <= 0) begin
      if (eac6 == 0) begin
        rg_n = REG_DEG;
      end else begin
        rg_n  = REG_AC;
        m1_n  = VAW'(d2);
        den_n = DENW'(eac6);
        for (int k = 0; k < 3; k++) e1x_n[k] = gac[6][k];
      end
    end else if (va6 <= 0 && e1_6 >= 0 && e2_6 >= 0) begin
      for (int k = 0; k < 3; k++) base_n[k] = gb[6][k];
      if (ebc == 0) begin
        rg_n = REG_DEG;
      end else begin
        rg_n  = REG_BC;
        m1_n  = VAW'(e1_6);
        den_n = DENW'(ebc);
        for (int k = 0; k < 3; k++) e1x_n[k] = gbc[6][k];
      end
    end else if (denom == 0) begin
      rg_n = REG_DEG;
    end else begin
      rg_n  = REG_IN;
      m1_n  = vb6;
      m2_n  = vc6;
      den_n = denom;
    end
  end

  logic signed [VAW-1:0]  m1_7, m2_7;
  logic signed [DFW-1:0]  e1x7 [3], e2x7 [3];
  logic signed [DENW-1:0] den [7:11];
  logic signed [CW-1:0]   bse [7:11][3];
  region_t                rg  [7:TOTAL];

  always_ff @(posedge clk) begin
    if (en) begin
      m1_7   <= m1_n;
      m2_7   <= m2_n;
      den[7] <= den_n;
      rg[7]  <= rg_n;
      for (int k = 0; k < 3; k++) begin
        e1x7[k]   <= e1x_n[k];
        e2x7[k]   <= gac[6][k];
        bse[7][k] <= base_n[k];
      end
      for (int i = 8; i <= 11; i++) begin
        den[i] <= den[i-1];
        for (int k = 0; k < 3; k++) bse[i][k] <= bse[i-1][k];
      end
      for (int i = 8; i <= TOTAL; i++) rg[i] <= rg[i-1];
    end
  end

  // Stage 8: chunk partial products of the numerator
  logic signed [PPW-1:0]     pq [3][2][NCH];
  logic signed [NCH*CHW-1:0] mx1, mx2;
  logic signed [CHW:0]       ch1 [NCH], ch2 [NCH];
  always_comb begin
    mx1 = (NCH*CHW)'(m1_7);
    mx2 = (NCH*CHW)'(m2_7);
    for (int j = 0; j < NCH; j++) begin
      if (j == NCH-1) begin
        ch1[j] = (CHW+1)'($signed(mx1[j*CHW +: CHW]));
        ch2[j] = (CHW+1)'($signed(mx2[j*CHW +: CHW]));
      end else begin
        ch1[j] = $signed({1'b0, mx1[j*CHW +: CHW]});
        ch2[j] = $signed({1'b0, mx2[j*CHW +: CHW]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < NCH; j++) begin
          pq[k][0][j] <= ch1[j] * e1x7[k];
          pq[k][1][j] <= ch2[j] * e2x7[k];
        end
      end
    end
  end

  // Stage 9: sum chunks of each term
  logic signed [TERMW-1:0] tm [3][2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int t = 0; t < 2; t++) begin
          tm[k][t] <= (TERMW'(pq[k][t][0]))
                    + (TERMW'(pq[k][t][1]) <<< CHW)
                    + (TERMW'(pq[k][t][2]) <<< (2*CHW))
                    + (TERMW'(pq[k][t][3]) <<< (3*CHW));
        end
      end
    end
  end

  // Stage 10: numerator per axis
  logic signed [NUMW-1:0] num [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) num[k] <= NUMW'(tm[k][0]) + NUMW'(tm[k][1]);
    end
  end

  // Stage 11: magnitudes and quotient sign
  logic [NUMW-1:0] un [3];
  logic [DENW-1:0] ud;
  logic            nq [3];
  always_ff @(posedge clk) begin
    if (en) begin
      ud <= den[10][DENW-1] ? DENW'(-den[10]) : DENW'(den[10]);
      for (int k = 0; k < 3; k++) begin
        un[k] <= num[k][NUMW-1] ? NUMW'(-num[k]) : NUMW'(num[k]);
        nq[k] <= num[k][NUMW-1] ^ den[10][DENW-1];
      end
    end
  end

  // Divide per axis, add base, clamp
  logic signed [CW-1:0] near [3];
  for (genvar k = 0; k < 3; k++) begin : g_axis
    cpt_div u_div (
      .clk  (clk),
      .en   (en),
      .un   (un[k]),
      .ud   (ud),
      .neg  (nq[k]),
      .base (bse[11][k]),
      .near (near[k])
    );
  end

  // Output word
  always_comb begin
    m_tdata = '0;
    for (int k = 0; k < 3; k++) m_tdata[k*CW +: CW] = near[k];
  end
  assign m_tuser = rg[TOTAL];

endmodule
`default_nettype wire

>>> rtl/cpt_check.sv
// Port-level checker for the closest-point pipeline, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cpt_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  input  logic [cpt_pkg::IN_W-1:0]      s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic [cpt_pkg::OUT_W-1:0]     m_tdata,
  input  logic [cpt_pkg::RGW-1:0]       m_tuser
);
  import cpt_pkg::*;

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Input is taken whenever the output is free or being drained
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output side");

  // Stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // Accepted input words carry known data
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown(s_tdata))
    else $error("accepted input word has unknown bits");

  // A valid output word carries known data
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown({m_tdata, m_tuser}))
    else $error("valid output word has unknown bits");

endmodule

bind closest_point_on_triangle cpt_check u_cpt_check (.*);
`default_nettype wire

>>> tb/closest_point_on_triangle_tb.sv
// Testbench for closest_point_on_triangle: streamed point/triangle words checked against a predictor.
`timescale 1ns / 1ps
module closest_point_on_triangle_tb;
  import cpt_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef wide_t vec_t [3];
  typedef struct {
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic [CW-1:0] nz;
    region_t       region;
  } nearest_t;

  localparam int HOLD_AT   = 700;
  localparam int WDOG_MAX  = 5000;
  localparam int N_RANDOM  = 1030;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic [RGW-1:0] m_tuser;

  logic [IN_W-1:0] pending_words [$];
  nearest_t nearest_q [$];
  int sent_cnt = 0;
  int got_cnt = 0;
  int errors = 0;
  int wdog = 0;
  int region_hits [8];

  closest_point_on_triangle uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Predictor: exact wide integer arithmetic, signed division truncates toward zero
  function automatic wide_t dot3(vec_t x, vec_t y);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  function automatic nearest_t saturate(vec_t v, region_t rg);
    nearest_t r;
    logic [CW-1:0] c [3];
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    for (int k = 0; k < 3; k++) begin
      if (v[k] > hi) c[k] = hi[CW-1:0];
      else if (v[k] < lo) c[k] = lo[CW-1:0];
      else c[k] = v[k][CW-1:0];
    end
    r.nx = c[0];
    r.ny = c[1];
    r.nz = c[2];
    r.region = rg;
    return r;
  endfunction

  function automatic nearest_t on_edge(vec_t base, vec_t dir, wide_t num, wide_t den,
                                       region_t rg);
    vec_t r;
    if (den == 0) return saturate(base, REG_DEG);
    for (int k = 0; k < 3; k++) r[k] = base[k] + (num * dir[k]) / den;
    return saturate(r, rg);
  endfunction

  function automatic nearest_t find_nearest(logic [IN_W-1:0] w);
    vec_t p, a, b, c, ab, ac, bc, ap, bp, cp, r;
    wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
    for (int k = 0; k < 3; k++) begin
      p[k] = wide_t'($signed(w[CW*k +: CW]));
      a[k] = wide_t'($signed(w[CW*(3+k) +: CW]));
      b[k] = wide_t'($signed(w[CW*(6+k) +: CW]));
      c[k] = wide_t'($signed(w[CW*(9+k) +: CW]));
      ab[k] = b[k] - a[k];
      ac[k] = c[k] - a[k];
      bc[k] = c[k] - b[k];
      ap[k] = p[k] - a[k];
      bp[k] = p[k] - b[k];
      cp[k] = p[k] - c[k];
    end
    d1 = dot3(ab, ap);
    d2 = dot3(ac, ap);
    if (d1 <= 0 && d2 <= 0) return saturate(a, REG_A);
    d3 = dot3(ab, bp);
    d4 = dot3(ac, bp);
    if (d3 >= 0 && d4 <= d3) return saturate(b, REG_B);
    d5 = dot3(ab, cp);
    d6 = dot3(ac, cp);
    if (d6 >= 0 && d5 <= d6) return saturate(c, REG_C);
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) return on_edge(a, ab, d1, d1 - d3, REG_AB);
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) return on_edge(a, ac, d2, d2 - d6, REG_AC);
    va = d3 * d6 - d5 * d4;
    e1 = d4 - d3;
    e2 = d5 - d6;
    if (va <= 0 && e1 >= 0 && e2 >= 0) return on_edge(b, bc, e1, e1 + e2, REG_BC);
    den = va + vb + vc;
    if (den == 0) return saturate(a, REG_DEG);
    for (int k = 0; k < 3; k++) r[k] = a[k] + (vb * ab[k] + vc * ac[k]) / den;
    return saturate(r, REG_IN);
  endfunction

  // Pack a query point and three vertices into one input word
  function automatic logic [IN_W-1:0] pack_word(int v [12]);
    logic [IN_W-1:0] w;
    w = '0;
    for (int k = 0; k < 12; k++) w[CW*k +: CW] = v[k][CW-1:0];
    return w;
  endfunction

  task automatic push_item(int px, int py, int pz, int ax, int ay, int az,
                           int bx, int by, int bz, int cx, int cy, int cz);
    int v [12];
    v = '{px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz};
    pending_words.insert(pending_words.size(), pack_word(v));
  endtask

  function automatic int any_coord();
    return int'($urandom_range(16777215)) - 8388608;
  endfunction

  function automatic int near_coord(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(2 * spread)) - spread;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  // Send words, idling at random except in a calm stretch and holding once until drained
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() > 0
          && !(sent_cnt == HOLD_AT && (s_tvalid || nearest_q.size() != 0))
          && ((sent_cnt >= 400 && sent_cnt < 600) || $urandom_range(99) >= 20)) begin
        s_tdata <= pending_words.pop_front();
        s_tvalid <= 1'b1;
        sent_cnt++;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output at random, with a calm stretch
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= (got_cnt >= 150 && got_cnt < 350) || $urandom_range(99) >= 20;
  end

  // Record expected results on input, check results on output, watch for a hang
  always @(posedge clk) begin
    nearest_t exp_r;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (nearest_q.size() == 0) begin
          $display("%0t: unexpected word: actual xyz=%h region=%0d",
                   $time, m_tdata, m_tuser);
          errors++;
        end else begin
          exp_r = nearest_q.pop_front();
          if (m_tdata[CW-1:0] !== exp_r.nx)
            $display("%0t: near_x expected %h actual %h", $time, exp_r.nx, m_tdata[CW-1:0]);
          if (m_tdata[2*CW-1:CW] !== exp_r.ny)
            $display("%0t: near_y expected %h actual %h", $time, exp_r.ny,
                     m_tdata[2*CW-1:CW]);
          if (m_tdata[3*CW-1:2*CW] !== exp_r.nz)
            $display("%0t: near_z expected %h actual %h", $time, exp_r.nz,
                     m_tdata[3*CW-1:2*CW]);
          if (m_tuser !== exp_r.region)
            $display("%0t: region expected %0d actual %0d", $time, exp_r.region, m_tuser);
          if (m_tdata[3*CW-1:0] !== {exp_r.nz, exp_r.ny, exp_r.nx}
              || m_tuser !== exp_r.region)
            errors++;
          region_hits[exp_r.region]++;
        end
        got_cnt++;
      end
      if (s_tvalid && s_tready) nearest_q.insert(nearest_q.size(), find_nearest(s_tdata));
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
        wdog = 0;
      end else begin
        wdog++;
        if (wdog >= WDOG_MAX) begin
          $display("%0t: no word moved for %0d cycles", $time, WDOG_MAX);
          $display("FAIL closest_point_on_triangle");
          $finish;
        end
      end
    end
  end

  initial begin
    int cx, cy, cz, ax, ay, az, bx, by, bz, kind, sp;
    // Directed: an all-zero word, then a unit right triangle with a query in every region
    push_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_item(-100, -100, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(5000, -10, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(-10, 5000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(2048, -500, 77, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(-500, 2048, -77, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(3000, 3000, 9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(1000, 1000, 500, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    push_item(1001, 333, -7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0);
    // Collinear vertices, zero-length edges, all vertices equal
    push_item(2000, 100, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0);
    push_item(6000, 300, 0, 0, 0, 0, 8192, 0, 0, 4096, 0, 0);
    push_item(5000, 5000, 5, 100, 100, 0, 100, 100, 0, 0, 8000, 0);
    push_item(5000, 5000, 5, 0, 0, 0, 8000, 0, 0, 8000, 0, 0);
    push_item(5000, -5000, 5, 0, 0, 0, 8000, 0, 0, 0, 0, 0);
    push_item(9, 9, 9, 7, 7, 7, 7, 7, 7, 7, 7, 7);
    // Field extremes
    push_item(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
              8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
    push_item(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
              -8388608, -8388608, -8388608, -8388608, -8388608, -8388608);
    push_item(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, -8388608, 0, -8388608, 8388607, 8388607);
    push_item(0, 0, 8388607, -8388608, -8388608, 0, 8388607, -8388608, 0, 0, 8388607, 0);
    push_item(0, 0, -8388608, -8388608, -8388608, 0, 8388607, -8388608, 0, 0, 8388607, 0);
    push_item(-8388608, 8388607, 0, 8388607, -8388608, 8388607, -8388608, 8388607,
              -8388608, 8388607, 8388607, -8388608);
    // Random: mostly local triangles with nearby queries, some full range and degenerate
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(9);
      sp = ($urandom_range(3) == 0) ? 4000000 : int'($urandom_range(20000, 10));
      cx = any_coord();
      cy = any_coord();
      cz = any_coord();
      ax = near_coord(cx, sp);
      ay = near_coord(cy, sp);
      az = near_coord(cz, sp);
      bx = near_coord(cx, sp);
      by = near_coord(cy, sp);
      bz = near_coord(cz, sp);
      if (kind < 2) begin
        push_item(any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord(), any_coord(), any_coord(), any_coord(),
                  any_coord(), any_coord());
      end else if (kind == 2) begin
        push_item(near_coord(cx, 2 * sp), near_coord(cy, 2 * sp), near_coord(cz, 2 * sp),
                  ax, ay, az, ax, ay, az, bx, by, bz);
      end else if (kind == 3) begin
        push_item(near_coord(cx, 2 * sp), near_coord(cy, 2 * sp), near_coord(cz, 2 * sp),
                  ax, ay, az, bx, by, bz, near_coord(ax, 0) + (bx - ax) / 2,
                  near_coord(ay, 0) + (by - ay) / 2, near_coord(az, 0) + (bz - az) / 2);
      end else begin
        push_item(near_coord(cx, 2 * sp), near_coord(cy, 2 * sp), near_coord(cz, 2 * sp),
                  ax, ay, az, bx, by, bz,
                  near_coord(cx, sp), near_coord(cy, sp), near_coord(cz, sp));
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || s_tvalid || nearest_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d words, got %0d; regions a/b/c %0d/%0d/%0d, edges %0d/%0d/%0d,",
             sent_cnt, got_cnt, region_hits[0], region_hits[1], region_hits[2],
             region_hits[3], region_hits[4], region_hits[5]);
    $display("interior %0d, degenerate %0d, mismatches %0d",
             region_hits[6], region_hits[7], errors);
    if (errors == 0 && nearest_q.size() == 0) begin
      $display("PASS closest_point_on_triangle");
    end else begin
      $display("FAIL closest_point_on_triangle");
    end
    $finish;
  end

endmodule
